@@ rtl/core/bpre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpre_pkg
// Shared types and constants for the button press / auto-repeat event core.
// ----------------------------------------------------------------------------
package bpre_pkg;

  localparam int CHAN_W   = 5;
  localparam int STATUS_W = 8;
  localparam int TIME_W   = 32;
  localparam int MASK_W   = 32;
  localparam int DELAY_W  = 16;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd3;

  localparam logic [STATUS_W-1:0] PRESSED_VALUE_RST = 8'd1;
  localparam logic [MASK_W-1:0]   INVERT_MASK_RST   = 32'd0;
  localparam logic [DELAY_W-1:0]  REPEAT_DELAY_RST  = 16'd500;
  localparam logic [DELAY_W-1:0]  REPEAT_PERIOD_RST = 16'd33;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 2'd0,
    KIND_PRESSED  = 2'd1,
    KIND_REPEAT   = 2'd2,
    KIND_RELEASED = 2'd3
  } kind_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   now_ms;
    logic                pressed;
    logic                in_range;
  } item_t;

endpackage

@@ rtl/core/bpre_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpre_front
// Unpacks an input sample and classifies it: channel range and pressed state.
// ----------------------------------------------------------------------------
module bpre_front #(
  parameter int CHANNELS = 32
) (
  input  logic [47:0]                   tdata,
  input  logic [bpre_pkg::STATUS_W-1:0] pressed_value,
  input  logic [bpre_pkg::MASK_W-1:0]   invert_mask,
  output bpre_pkg::item_t               item
);
  import bpre_pkg::*;

  logic [CHAN_W-1:0]   chan;
  logic [STATUS_W-1:0] status;
  logic                hit;
  logic                inv;

  assign chan   = tdata[CHAN_W-1:0];
  assign status = tdata[CHAN_W +: STATUS_W];
  assign hit    = (status == pressed_value);
  assign inv    = invert_mask[chan];

  always_comb begin
    item.chan     = chan;
    item.status   = status;
    item.now_ms   = tdata[CHAN_W+STATUS_W +: TIME_W];
    item.pressed  = hit ^ inv;
    item.in_range = (32'(chan) < CHANNELS);
  end

endmodule

@@ rtl/core/bpre_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpre_fifo
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module bpre_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  bpre_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output bpre_pkg::item_t rd_item,
  output logic            not_empty
);
  import bpre_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_item;
  end

endmodule

@@ rtl/core/bpre_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpre_back
// Per-channel state table and event decision, with a registered result.
// ----------------------------------------------------------------------------
module bpre_back #(
  parameter int CHANNELS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bpre_pkg::item_t                item,
  input  logic                           item_valid,
  output logic                           item_pop,
  input  logic [bpre_pkg::DELAY_W-1:0]   repeat_delay_ms,
  input  logic [bpre_pkg::DELAY_W-1:0]   repeat_period_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpre_pkg::CHAN_W-1:0]    out_chan,
  output bpre_pkg::kind_t                out_kind
);
  import bpre_pkg::*;

  // the channel field only reaches 32 entries
  localparam int DEPTH = (CHANNELS < 32) ? CHANNELS : 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [STATUS_W-1:0] prev_status [DEPTH];
  logic [TIME_W-1:0]   last_stamp  [DEPTH];
  logic [DEPTH-1:0]    armed;

  logic [IDX_W-1:0]    idx;
  logic [STATUS_W-1:0] last;
  logic [TIME_W-1:0]   elapsed;
  logic                changed;
  logic                in_delay;
  logic                period_hit;
  kind_t               kind;
  logic                stamp_wr;
  logic                armed_wr;
  logic                armed_val;

  assign idx        = item.chan[IDX_W-1:0];
  assign last       = prev_status[idx];
  assign elapsed    = item.now_ms - last_stamp[idx];
  assign changed    = (item.status != last);
  assign in_delay   = armed[idx] && (elapsed < {16'd0, repeat_delay_ms});
  assign period_hit = (elapsed >= {16'd0, repeat_period_ms});
  assign item_pop   = item_valid && (!out_valid || out_ready);

  always_comb begin
    kind      = KIND_NONE;
    stamp_wr  = 1'b0;
    armed_wr  = 1'b0;
    armed_val = 1'b0;
    if (item.in_range) begin
      if (!item.pressed) begin
        kind = changed ? KIND_RELEASED : KIND_NONE;
      end else if (changed) begin
        kind      = KIND_PRESSED;
        stamp_wr  = 1'b1;
        armed_wr  = 1'b1;
        armed_val = 1'b1;
      end else if (in_delay) begin
        // first held sample inside the delay window: restart timing
        stamp_wr  = 1'b1;
        armed_wr  = 1'b1;
        armed_val = 1'b0;
      end else if (period_hit) begin
        kind     = KIND_REPEAT;
        stamp_wr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        prev_status[i] <= '0;
        last_stamp[i]  <= '0;
      end
      armed <= '0;
    end else if (item_pop && item.in_range) begin
      prev_status[idx] <= item.status;
      if (stamp_wr) last_stamp[idx] <= item.now_ms;
      if (armed_wr) armed[idx] <= armed_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_chan <= item.chan;
      out_kind <= kind;
    end
  end

endmodule

@@ rtl/core/button_press_repeat_events_core.sv @@
`timescale 1ns / 1ps
// A sample is queued, then its result is registered as it is popped from the queue.
// Throughput: one sample per cycle unless m_axis_tready stalls; state is updated as it pops.
// A two-entry queue separates classification from the state table.
// Reset (rst, synchronous) clears all per-channel state at once and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// button_press_repeat_events_core
// Button sample in, press / repeat / release event out, per channel.
// ----------------------------------------------------------------------------
module button_press_repeat_events_core #(
  parameter int CHANNELS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // channel, raw_status, now_ms, pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // event_channel, pad
  output logic [1:0]                        m_axis_tuser,  // event_kind
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpre_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bpre_pkg::*;

  logic [STATUS_W-1:0] pressed_value;
  logic [MASK_W-1:0]   invert_mask;
  logic [DELAY_W-1:0]  repeat_delay_ms;
  logic [DELAY_W-1:0]  repeat_period_ms;

  item_t               front_item;
  item_t               back_item;
  logic                fifo_full;
  logic                fifo_not_empty;
  logic                pop;
  logic                in_xfer;
  logic [CHAN_W-1:0]   out_chan;
  kind_t               out_kind;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !fifo_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {3'd0, out_chan};
  assign m_axis_tuser  = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_value    <= PRESSED_VALUE_RST;
      invert_mask      <= INVERT_MASK_RST;
      repeat_delay_ms  <= REPEAT_DELAY_RST;
      repeat_period_ms <= REPEAT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESSED_VALUE: pressed_value    <= cfg_data[STATUS_W-1:0];
        REG_INVERT_MASK:   invert_mask      <= cfg_data[MASK_W-1:0];
        REG_REPEAT_DELAY:  repeat_delay_ms  <= cfg_data[DELAY_W-1:0];
        REG_REPEAT_PERIOD: repeat_period_ms <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  bpre_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .tdata         (s_axis_tdata),
    .pressed_value (pressed_value),
    .invert_mask   (invert_mask),
    .item          (front_item)
  );

  bpre_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_xfer),
    .wr_item   (front_item),
    .full      (fifo_full),
    .rd_en     (pop),
    .rd_item   (back_item),
    .not_empty (fifo_not_empty)
  );

  bpre_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .item             (back_item),
    .item_valid       (fifo_not_empty),
    .item_pop         (pop),
    .repeat_delay_ms  (repeat_delay_ms),
    .repeat_period_ms (repeat_period_ms),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_chan         (out_chan),
    .out_kind         (out_kind)
  );

endmodule
